FILE: sv/hpb_pkg.sv
// ----------------------------------------------------------------------------
// hpb_pkg: shared definitions for the horizontal-to-page bitmap converter
// Sizes, register indexes, reset values, the block type handed between the
// front end and the emitter, and the 8x8 bit transpose.
// ----------------------------------------------------------------------------
package hpb_pkg;

  // Widest bitmap, in bytes, whose lines are kept in the strip store.
  localparam int unsigned MAX_COLUMNS  = 16;
  localparam int unsigned STORED_LINES = 7;
  localparam int unsigned BLOCK_SIZE   = 8;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned COL_W  = 5;
  localparam int unsigned PAGE_W = 5;
  localparam int unsigned LINE_W = 3;
  localparam int unsigned BEAT_W = 3;
  localparam int unsigned ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES   = 1'd1;

  localparam logic [COL_W-1:0]  COLUMNS_RESET = 5'd16;
  localparam logic [PAGE_W-1:0] PAGES_RESET   = 5'd8;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [BLOCK_SIZE-1:0][BYTE_W-1:0] block_t;

  // One complete 8x8 block on its way to the emitter.
  typedef struct packed {
    block_t lines;       // lines[i] is line i of the strip
    logic   frame_last;  // block is the final one of the frame
  } blk_t;

  // Column j of the result has bit 7-i equal to bit 7-j of line i.
  function automatic block_t transpose(block_t lines);
    block_t res;
    for (int j = 0; j < BLOCK_SIZE; j++) begin
      for (int i = 0; i < BLOCK_SIZE; i++) begin
        res[j][BYTE_W-1-i] = lines[i][BYTE_W-1-j];
      end
    end
    return res;
  endfunction

endpackage

FILE: sv/hpb_if.sv
// ----------------------------------------------------------------------------
// hpb_if: channel interfaces of the horizontal-to-page bitmap converter
// Pixel input channel, page output channel and configuration write channel,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface hpb_pix_if import hpb_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface hpb_page_if import hpb_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t page_byte;
  logic  last_of_block;
  logic  last_of_frame;

  modport source (output valid, output page_byte, output last_of_block,
                  output last_of_frame, input ready);
  modport sink   (input valid, input page_byte, input last_of_block,
                  input last_of_frame, output ready);
endinterface

interface hpb_cfg_if import hpb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/horizontal_to_page_bitmap.sv
// ----------------------------------------------------------------------------
// horizontal_to_page_bitmap: horizontal-mode to page-mode bitmap converter
// Turns raster-order pixel bytes into page bytes, one 8x8 block at a time.
// ----------------------------------------------------------------------------
// Pixel bytes of the first seven lines of each eight-line strip are taken one
// per cycle while the input is not held off, and written into a 7 x 16 byte
// strip store; each byte of the eighth line completes a block and yields
// eight page bytes, sent one beat per cycle from the output block register
// while the output is ready. The input keeps accepting while a block is still
// being sent: a store byte passes at once, and the next eighth-line byte
// waits in the stage register, holding off further input, until the last
// beat of the current block leaves. The first page byte of a block reaches
// the output once its eighth-line byte has passed the stage register and been
// loaded into the output block register. The strip store has no reset and
// needs no clearing; columns beyond the sixteenth are not stored and read as
// zero. The user must write the size registers only while the block is idle;
// the block itself does not enforce this. A size of zero acts as one.
// ----------------------------------------------------------------------------
module horizontal_to_page_bitmap import hpb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hpb_cfg_if.sink    cfg_i,
  hpb_pix_if.sink    pix_i,
  hpb_page_if.source page_o
);

  logic blk_valid;
  logic blk_ready;
  blk_t blk;

  hpb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pix_i       (pix_i),
    .blk_valid_o (blk_valid),
    .blk_o       (blk),
    .blk_ready_i (blk_ready)
  );

  hpb_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (blk_valid),
    .blk_i       (blk),
    .blk_ready_o (blk_ready),
    .page_o      (page_o)
  );

  // The frame ends only on the last beat of a block.
  a_frame_on_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_o.valid && page_o.last_of_frame |-> page_o.last_of_block)
    else $error("last_of_frame without last_of_block");

  // With nothing on the output, the input never stalls.
  a_idle_output_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !page_o.valid |-> pix_i.ready)
    else $error("input stalled while output is empty");

  // A block once started is sent without gaps until its last beat.
  a_block_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_o.valid && page_o.ready && !page_o.last_of_block |=> page_o.valid)
    else $error("block output stopped before its last beat");

endmodule

FILE: sv/hpb_front.sv
// ----------------------------------------------------------------------------
// hpb_front: input side of the converter
// Holds the size registers and the raster counters, writes the first seven
// lines of each strip into the strip store, and on an eighth-line byte reads
// the matching column back into a stage register as a complete 8x8 block.
// ----------------------------------------------------------------------------
module hpb_front import hpb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  hpb_cfg_if.sink cfg_i,
  hpb_pix_if.sink pix_i,
  output logic   blk_valid_o,
  output blk_t   blk_o,
  input  logic   blk_ready_i
);

  logic [COL_W-1:0]  columns_q;
  logic [PAGE_W-1:0] pages_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [LINE_W-1:0] line_q, line_d;

  logic              accept;
  logic              eighth_line;
  logic              in_range;
  logic              last_col, last_page;
  logic [COL_W-1:0]  col_limit;
  logic [PAGE_W-1:0] page_limit;
  logic [ADDR_W-1:0] addr;

  // Strip store: one row per column, one byte lane per stored line.
  byte_t             strip_mem_q [MAX_COLUMNS][STORED_LINES];
  byte_t             rd_q [STORED_LINES];

  logic              s1_valid_q;
  logic              s1_block_q;
  logic              s1_in_range_q;
  logic              s1_frame_q;
  byte_t             s1_byte_q;
  logic              s1_drain;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      pages_q   <= PAGES_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_COLUMNS: columns_q <= cfg_i.data;
        REG_PAGES:   pages_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A size of zero counts as one.
  assign col_limit  = (columns_q == '0) ? COL_W'(1) : columns_q;
  assign page_limit = (pages_q == '0) ? PAGE_W'(1) : pages_q;
  assign last_col   = ({1'b0, col_q} + (COL_W+1)'(1)) >= {1'b0, col_limit};
  assign last_page  = ({1'b0, page_q} + (PAGE_W+1)'(1)) >= {1'b0, page_limit};

  assign eighth_line = (line_q == LINE_W'(STORED_LINES));
  assign in_range    = ({1'b0, col_q} < (COL_W+1)'(MAX_COLUMNS));
  assign addr        = col_q[ADDR_W-1:0];

  // The stage register empties when it holds a plain store beat or when
  // the emitter takes its block.
  assign s1_drain    = !s1_block_q || blk_ready_i;
  assign pix_i.ready = !s1_valid_q || s1_drain;
  assign accept      = pix_i.valid && pix_i.ready;

  // Raster counters: column within line, line within strip, strip.
  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    page_d = page_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        if (eighth_line) begin
          line_d = '0;
          page_d = last_page ? '0 : page_q + PAGE_W'(1);
        end else begin
          line_d = line_q + LINE_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
      page_q <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
      page_q <= page_d;
    end
  end

  // Strip store write for lines 0 to 6, registered row read for line 7.
  always_ff @(posedge clk_i) begin
    if (accept && !eighth_line && in_range) begin
      strip_mem_q[addr][line_q] <= pix_i.pixel_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= strip_mem_q[addr];
    end
  end

  // Stage register beside the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_block_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_block_q <= eighth_line;
    end else if (s1_drain) begin
      s1_valid_q <= 1'b0;
      s1_block_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q     <= pix_i.pixel_byte;
      s1_in_range_q <= in_range;
      s1_frame_q    <= last_col && last_page;
    end
  end

  // Assemble the block; columns beyond the store read as zero.
  always_comb begin
    for (int i = 0; i < STORED_LINES; i++) begin
      blk_o.lines[i] = s1_in_range_q ? rd_q[i] : '0;
    end
    blk_o.lines[STORED_LINES] = s1_byte_q;
    blk_o.frame_last          = s1_frame_q;
  end

  assign blk_valid_o = s1_valid_q && s1_block_q;

endmodule

FILE: sv/hpb_emit.sv
// ----------------------------------------------------------------------------
// hpb_emit: output side of the converter
// Transposes a complete 8x8 block into page bytes and sends them as eight
// output beats from a block register, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module hpb_emit import hpb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      blk_valid_i,
  input  blk_t      blk_i,
  output logic      blk_ready_o,
  hpb_page_if.source page_o
);

  block_t            cols_q;
  logic [BEAT_W-1:0] beat_q;
  logic              valid_q;
  logic              frame_q;
  logic              take;
  logic              last_beat;
  logic              load;

  assign last_beat   = (beat_q == BEAT_W'(BLOCK_SIZE-1));
  assign take        = page_o.valid && page_o.ready;
  // A new block may enter when the register is empty or its last beat leaves.
  assign blk_ready_o = !valid_q || (take && last_beat);
  assign load        = blk_valid_i && blk_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      beat_q  <= '0;
    end else if (take) begin
      if (last_beat) begin
        valid_q <= 1'b0;
      end
      beat_q <= beat_q + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cols_q  <= transpose(blk_i.lines);
      frame_q <= blk_i.frame_last;
    end
  end

  assign page_o.valid         = valid_q;
  assign page_o.page_byte     = cols_q[beat_q];
  assign page_o.last_of_block = last_beat;
  assign page_o.last_of_frame = last_beat && frame_q;

endmodule

FILE: test/hpb_checker.sv
// ----------------------------------------------------------------------------
// hpb_checker: page beat predictor and scoreboard for the bitmap converter
// Watches the configuration, pixel and page channels. It keeps its own copy
// of the size registers, the strip position and the strip store, predicts
// the eight page beats of every completed 8x8 block, and compares each
// accepted page beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hpb_checker import hpb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pix_valid_i,
  input  logic                  pix_ready_i,
  input  byte_t                 pixel_byte_i,
  input  logic                  page_valid_i,
  input  logic                  page_ready_i,
  input  byte_t                 page_byte_i,
  input  logic                  last_of_block_i,
  input  logic                  last_of_frame_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  typedef struct packed {
    byte_t page_byte;
    logic  last_of_block;
    logic  last_of_frame;
  } page_beat_t;

  // Page beats predicted but not yet seen on the output, oldest first.
  page_beat_t expected_beats[$];

  // Shadow of the block: size registers, strip position and stored lines.
  byte_t             strip_lines [STORED_LINES][MAX_COLUMNS];
  logic [COL_W-1:0]  width_reg;
  logic [PAGE_W-1:0] height_reg;
  logic [LINE_W-1:0] line_pos;
  logic [COL_W-1:0]  col_pos;
  logic [PAGE_W-1:0] page_pos;
  int unsigned       mismatches;

  // Reports one field of a page beat that differs from its prediction.
  function automatic bit field_differs(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: page beat %s expected 0x%02h, got 0x%02h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned cols_lim;
    int unsigned pages_lim;
    logic        last_col;
    logic        last_page;
    block_t      rows;
    byte_t       column_bits;
    page_beat_t  want;

    if (!rst_ni) begin
      expected_beats.delete();
      width_reg  = COLUMNS_RESET;
      height_reg = PAGES_RESET;
      line_pos   = '0;
      col_pos    = '0;
      page_pos   = '0;
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // Register writes.
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_COLUMNS) begin
          width_reg = cfg_data_i;
        end else if (cfg_index_i == REG_PAGES) begin
          height_reg = cfg_data_i;
        end
      end

      // Compare an accepted page beat with the oldest prediction.
      if (page_valid_i && page_ready_i) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: page beat 0x%02h (last_of_block %b, last_of_frame %b), none expected",
                   $time, page_byte_i, last_of_block_i, last_of_frame_i);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          mismatches += field_differs("page_byte", want.page_byte, page_byte_i);
          mismatches += field_differs("last_of_block", 8'(want.last_of_block),
                                      8'(last_of_block_i));
          mismatches += field_differs("last_of_frame", 8'(want.last_of_frame),
                                      8'(last_of_frame_i));
        end
      end

      // Store a pixel byte, or complete a block on the eighth line.
      if (pix_valid_i && pix_ready_i) begin
        cols_lim  = (width_reg == 0) ? 1 : int'(width_reg);
        pages_lim = (height_reg == 0) ? 1 : int'(height_reg);
        last_col  = (int'(col_pos) + 1) >= cols_lim;
        last_page = (int'(page_pos) + 1) >= pages_lim;

        if (line_pos < STORED_LINES) begin
          if (col_pos < MAX_COLUMNS) begin
            strip_lines[line_pos][col_pos] = pixel_byte_i;
          end
        end else begin
          // Columns beyond the store read as blank lines.
          for (int i = 0; i < STORED_LINES; i++) begin
            rows[i] = '0;
            if (col_pos < MAX_COLUMNS) begin
              rows[i] = strip_lines[i][col_pos];
            end
          end
          rows[STORED_LINES] = pixel_byte_i;
          for (int j = 0; j < BLOCK_SIZE; j++) begin
            for (int i = 0; i < BLOCK_SIZE; i++) begin
              column_bits[BYTE_W-1-i] = rows[i][BYTE_W-1-j];
            end
            want.page_byte     = column_bits;
            want.last_of_block = (j == BLOCK_SIZE - 1);
            want.last_of_frame = (j == BLOCK_SIZE - 1) && last_col && last_page;
            expected_beats.push_back(want);
          end
        end

        // Advance column, line and page; a limit is hit at or above it.
        if (last_col) begin
          col_pos = '0;
          if (line_pos >= STORED_LINES) begin
            line_pos = '0;
            page_pos = last_page ? '0 : page_pos + 1'b1;
          end else begin
            line_pos = line_pos + 1'b1;
          end
        end else begin
          col_pos = col_pos + 1'b1;
        end
      end

      pending_o <= expected_beats.size();
      errors_o  <= mismatches;
    end
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for the horizontal-to-page bitmap converter
// Drives pixel bytes and size register writes into the converter, applies
// random gaps on the pixel side and random stalls on the page side, and
// leaves prediction and comparison to the checker beside it. A short
// directed part covers extreme bytes, zero sizes and size changes in the
// middle of a frame; a random frame wider than the strip store follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import hpb_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef enum {PACE_STEADY, PACE_SRC_GAPS, PACE_SNK_STALLS, PACE_BOTH} pace_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned src_gap_pct   = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned pending_beats;
  int unsigned error_count;

  // Directed pixel bytes: extremes and single-bit patterns.
  byte_t edge_frame [8] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F};
  byte_t strip_tail [7] = '{8'h81, 8'h42, 8'h24, 8'h18, 8'h7E, 8'hC3, 8'h99};
  byte_t diag_strip [8] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};

  hpb_cfg_if  cfg  ();
  hpb_pix_if  pix  ();
  hpb_page_if page ();

  horizontal_to_page_bitmap i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix),
    .page_o (page)
  );

  hpb_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg.valid),
    .cfg_ready_i     (cfg.ready),
    .cfg_index_i     (cfg.index),
    .cfg_data_i      (cfg.data),
    .pix_valid_i     (pix.valid),
    .pix_ready_i     (pix.ready),
    .pixel_byte_i    (pix.pixel_byte),
    .page_valid_i    (page.valid),
    .page_ready_i    (page.ready),
    .page_byte_i     (page.page_byte),
    .last_of_block_i (page.last_of_block),
    .last_of_frame_i (page.last_of_frame),
    .pending_o       (pending_beats),
    .errors_o        (error_count)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Page side: stall at random according to the current pace.
  always @(posedge clk_i) begin
    page.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (page.valid && page.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("horizontal_to_page_bitmap regression: fail");
      $finish;
    end
  end

  task automatic set_pace(input pace_e mode);
    case (mode)
      PACE_STEADY: begin
        src_gap_pct   = 0;
        snk_stall_pct = 0;
      end
      PACE_SRC_GAPS: begin
        src_gap_pct   = 58;
        snk_stall_pct = 0;
      end
      PACE_SNK_STALLS: begin
        src_gap_pct   = 0;
        snk_stall_pct = 58;
      end
      default: begin
        src_gap_pct   = 6;
        snk_stall_pct = 6;
      end
    endcase
  endtask

  // One register write; valid is lowered on the accepting edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] pages);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_PAGES, pages);
  endtask

  // One pixel beat, after a random number of idle cycles. Valid stays high
  // on return so that back-to-back beats need no extra assignment.
  task automatic send_pixel(input byte_t value);
    while ($urandom_range(99) < src_gap_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid      <= 1'b1;
    pix.pixel_byte <= value;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(byte_t'($urandom_range(255)));
  endtask

  // Waits until every predicted page beat has come out, then lets the
  // block settle before the next register write.
  task automatic wait_drained();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_frame(input pace_e mode, input int unsigned cols, input int unsigned pages);
    set_pace(mode);
    configure(CFG_DATA_W'(cols), CFG_DATA_W'(pages));
    send_random(cols * pages * BLOCK_SIZE);
    wait_drained();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.index      <= REG_COLUMNS;
    cfg.data       <= '0;
    pix.valid      <= 1'b0;
    pix.pixel_byte <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero sizes act as a single 8x8 block; extreme and alternating bytes.
    set_pace(PACE_STEADY);
    configure('0, '0);
    foreach (edge_frame[k]) send_pixel(edge_frame[k]);
    wait_drained();

    // Width shrinks below the current column, then height below the
    // current page, both in the middle of a frame.
    set_pace(PACE_SNK_STALLS);
    configure(5'd3, 5'd31);
    send_pixel(8'h3C);
    send_pixel(8'hC3);
    wait_drained();
    write_reg(REG_COLUMNS, 5'd1);
    send_pixel(8'hE7);
    foreach (strip_tail[k]) send_pixel(strip_tail[k]);
    wait_drained();
    set_pace(PACE_BOTH);
    write_reg(REG_PAGES, 5'd1);
    foreach (diag_strip[k]) send_pixel(diag_strip[k]);
    wait_drained();

    // A random frame one column wider than the strip store.
    run_frame(PACE_SRC_GAPS, 17, 1);

    if (error_count == 0) begin
      $display("horizontal_to_page_bitmap regression: pass");
    end else begin
      $display("horizontal_to_page_bitmap regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/hpb_pkg.sv
sv/hpb_if.sv
sv/hpb_front.sv
sv/hpb_emit.sv
sv/horizontal_to_page_bitmap.sv
test/hpb_checker.sv
test/testbench.sv
